// File: rtl/btc_pkg.sv
// Shared types, widths and constants for the barometer compensation pipeline.
// No dependencies; every other file imports this package.
package btc_pkg;

    // Field widths at the ports
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int PRES_W  = 26;
    localparam int TEMP_W  = 19;

    // Internal widths, sized to the reachable value ranges
    localparam int DT_W     = RAW_W + 1;          // raw_temperature - reference*256
    localparam int MUL_W    = DT_W + CAL_W + 1;   // dT times a calibration word
    localparam int SH_T     = 23;
    localparam int SH_OFF   = 7;
    localparam int SH_SENS  = 8;
    localparam int SH_T2    = 31;
    localparam int SH_P1    = 21;
    localparam int SH_P2    = 15;
    localparam int OFF_W    = MUL_W - SH_OFF;     // 35
    localparam int SENS_W   = MUL_W - SH_SENS;    // 34
    localparam int T2_W     = 17;
    localparam int TW_W     = TEMP_W + 1;         // temperature with a guard bit
    localparam int SQ_W     = 35;
    localparam int OFF_F_W  = 40;
    localparam int SENS_F_W = 39;
    localparam int SLO_W    = 20;                 // low slice of SENS for the split product
    localparam int SHI_W    = SENS_F_W - SLO_W;
    localparam int PP_W     = RAW_W + SLO_W;      // partial product width
    localparam int PROD_W   = 64;
    localparam int Q_W      = PROD_W - SH_P1;
    localparam int R_W      = Q_W + 1;
    localparam int PF_W     = R_W - SH_P2;

    // Temperature thresholds in 0.01 C
    localparam int T_REF   = 2000;
    localparam int T_VCOLD = -1500;
    localparam int T_HOT   = 4500;

    // Calibration reset values
    localparam logic [CAL_W-1:0] RST_PSENS = 16'd40127;
    localparam logic [CAL_W-1:0] RST_POFF  = 16'd36924;
    localparam logic [CAL_W-1:0] RST_STC   = 16'd23317;
    localparam logic [CAL_W-1:0] RST_OTC   = 16'd23282;
    localparam logic [CAL_W-1:0] RST_TREF  = 16'd33464;
    localparam logic [CAL_W-1:0] RST_SLOPE = 16'd28312;

    // Register map indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        CFG_PSENS = 3'd0,
        CFG_POFF  = 3'd1,
        CFG_STC   = 3'd2,
        CFG_OTC   = 3'd3,
        CFG_TREF  = 3'd4,
        CFG_SLOPE = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_slope;
    } cfg_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } raw_t;

    // First-order terms
    typedef struct packed {
        logic [RAW_W-1:0]         d1;
        logic signed [TEMP_W-1:0] temp;
        logic signed [OFF_W-1:0]  off;
        logic signed [SENS_W-1:0] sens;
        logic [T2_W-1:0]          t2;
    } first_t;

    // Corrected terms
    typedef struct packed {
        logic [RAW_W-1:0]           d1;
        logic signed [TEMP_W-1:0]   tc;
        logic signed [OFF_F_W-1:0]  off;
        logic signed [SENS_F_W-1:0] sens;
    } corr_t;

    typedef struct packed {
        logic signed [PRES_W-1:0] pressure_pa;
        logic signed [TEMP_W-1:0] temperature_centi;
    } result_t;

endpackage

// File: rtl/barometer_temperature_compensation.sv
// Top level of the second-order barometer compensation pipeline.
// Depends on btc_pkg, btc_cfg, btc_first, btc_corr and btc_press.
//
//   Channel | Direction | Handshake          | Contents
//   --------+-----------+--------------------+------------------------------------------
//   s_      | in        | s_tvalid/s_tready  | raw pressure and raw temperature request
//   m_      | out       | m_tvalid/m_tready  | compensated pressure and temperature
//   APB     | in        | psel/penable       | six calibration words, 4-byte stride
//
// Rate: one request per cycle while the output is not stalled; eight register stages lie
// between acceptance and m_tvalid (three first-order, two correction, three pressure,
// the last being the output register).
// Reset: aresetn is synchronous and active low; it empties every stage and
// loads the calibration defaults.
// Stalls: each stage holds while it is full and the one after it cannot take,
// so bubbles are squeezed out and new requests enter while a result waits.
module barometer_temperature_compensation
    import btc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [25:0] pressure_pa, [44:26] temperature_centi, pad
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg;
    raw_t    raw;
    first_t  first_data;
    corr_t   corr_data;
    result_t res;
    logic    first_valid, corr_in_ready;
    logic    corr_valid, press_in_ready;

    // Calibration words
    btc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Unpack the request
    assign raw.raw_pressure    = s_tdata[RAW_W-1:0];
    assign raw.raw_temperature = s_tdata[2*RAW_W-1:RAW_W];

    // dT, first-order temperature, offset and sensitivity
    btc_first u_first (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (raw),
        .out_valid (first_valid),
        .out_ready (corr_in_ready),
        .out_data  (first_data)
    );

    // Cold, very cold and hot corrections
    btc_corr u_corr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (first_valid),
        .in_ready  (corr_in_ready),
        .in_data   (first_data),
        .out_valid (corr_valid),
        .out_ready (press_in_ready),
        .out_data  (corr_data)
    );

    // Pressure product, offset removal and saturation; owns the output register
    btc_press u_press (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (corr_valid),
        .in_ready  (press_in_ready),
        .in_data   (corr_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    // Pack the result, low field first, zero pad to whole bytes
    assign m_tdata = {3'b000, res.temperature_centi, res.pressure_pa};

    // The pipeline only refuses a request when every stage is full behind a
    // stalled output
    a_refuse_only_when_blocked: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready)
    ) else $error("input refused while the output is not stalled");

    // Back-pressure travels upstream in order
    a_backpressure_order: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !corr_in_ready |-> !press_in_ready
    ) else $error("correction stages stalled without pressure stages stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (
        @(posedge aclk)
        !aresetn |=> !m_tvalid
    ) else $error("result presented straight after reset");

endmodule

// File: rtl/btc_cfg.sv
// Calibration register bank behind a simple APB-style port.
// Depends on btc_pkg.
module btc_cfg
    import btc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    cfg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = cfg_idx_t'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pressure_sensitivity   <= RST_PSENS;
            cfg_reg.pressure_offset        <= RST_POFF;
            cfg_reg.sensitivity_temp_coeff <= RST_STC;
            cfg_reg.offset_temp_coeff      <= RST_OTC;
            cfg_reg.reference_temperature  <= RST_TREF;
            cfg_reg.temperature_slope      <= RST_SLOPE;
        end else if (wr) begin
            case (idx)
                CFG_PSENS: cfg_reg.pressure_sensitivity   <= pwdata[CAL_W-1:0];
                CFG_POFF:  cfg_reg.pressure_offset        <= pwdata[CAL_W-1:0];
                CFG_STC:   cfg_reg.sensitivity_temp_coeff <= pwdata[CAL_W-1:0];
                CFG_OTC:   cfg_reg.offset_temp_coeff      <= pwdata[CAL_W-1:0];
                CFG_TREF:  cfg_reg.reference_temperature  <= pwdata[CAL_W-1:0];
                CFG_SLOPE: cfg_reg.temperature_slope      <= pwdata[CAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            CFG_PSENS: prdata = {16'h0, cfg_reg.pressure_sensitivity};
            CFG_POFF:  prdata = {16'h0, cfg_reg.pressure_offset};
            CFG_STC:   prdata = {16'h0, cfg_reg.sensitivity_temp_coeff};
            CFG_OTC:   prdata = {16'h0, cfg_reg.offset_temp_coeff};
            CFG_TREF:  prdata = {16'h0, cfg_reg.reference_temperature};
            CFG_SLOPE: prdata = {16'h0, cfg_reg.temperature_slope};
            default:   prdata = 32'h0;
        endcase
    end

endmodule

// File: rtl/btc_first.sv
// First-order stages: dT, the three dT products and dT squared, then T, OFF, SENS.
// Three register stages; depends on btc_pkg.
module btc_first
    import btc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  raw_t   in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output first_t out_data
);

    logic [2:0] vld_reg;
    logic       en1, en2, en3;

    // stage 1
    logic [RAW_W-1:0]        d1_1_reg;
    logic signed [DT_W-1:0]  dt_next, dt_reg;
    // stage 2
    logic [RAW_W-1:0]        d1_2_reg;
    logic signed [MUL_W-1:0] mt_next, mt_reg;
    logic signed [MUL_W-1:0] mo_next, mo_reg;
    logic signed [MUL_W-1:0] ms_next, ms_reg;
    logic signed [2*DT_W-1:0] sq_full;
    logic [T2_W-1:0]         t2_next, t2_reg;
    // stage 3
    first_t                  first_next, first_reg;

    assign en3      = !vld_reg[2] || out_ready;
    assign en2      = !vld_reg[1] || en3;
    assign en1      = !vld_reg[0] || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en1) vld_reg[0] <= in_valid;
            if (en2) vld_reg[1] <= vld_reg[0];
            if (en3) vld_reg[2] <= vld_reg[1];
        end
    end

    // dT, exact in DT_W bits
    assign dt_next = $signed({1'b0, in_data.raw_temperature})
                   - $signed({1'b0, cfg.reference_temperature, 8'h00});

    assign mt_next = dt_reg * $signed({1'b0, cfg.temperature_slope});
    assign mo_next = dt_reg * $signed({1'b0, cfg.offset_temp_coeff});
    assign ms_next = dt_reg * $signed({1'b0, cfg.sensitivity_temp_coeff});
    assign sq_full = dt_reg * dt_reg;
    assign t2_next = sq_full[SH_T2+T2_W-1:SH_T2];

    always_comb begin
        first_next.d1   = d1_2_reg;
        first_next.temp = $signed(mt_reg[MUL_W-1:SH_T]) + TEMP_W'(T_REF);
        first_next.off  = $signed({3'b000, cfg.pressure_offset, 16'h0000})
                        + $signed(mo_reg[MUL_W-1:SH_OFF]);
        first_next.sens = $signed({3'b000, cfg.pressure_sensitivity, 15'h0000})
                        + $signed(ms_reg[MUL_W-1:SH_SENS]);
        first_next.t2   = t2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            d1_1_reg <= in_data.raw_pressure;
            dt_reg   <= dt_next;
        end
        if (en2) begin
            d1_2_reg <= d1_1_reg;
            mt_reg   <= mt_next;
            mo_reg   <= mo_next;
            ms_reg   <= ms_next;
            t2_reg   <= t2_next;
        end
        if (en3) begin
            first_reg <= first_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = first_reg;

endmodule

// File: rtl/btc_corr.sv
// Second-order correction stages: squared temperature distances, then OFF2,
// SENS2 and T2 applied. Two register stages; depends on btc_pkg.
module btc_corr
    import btc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  first_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output corr_t  out_data
);

    logic [1:0] vld_reg;
    logic       en1, en2;

    // stage 1
    logic signed [TW_W-1:0]   tw;
    logic signed [TW_W-1:0]   dc, dv, dh;
    logic signed [2*TW_W-1:0] sqc_full, sqv_full, sqh_full;
    first_t                   f_reg;
    logic [SQ_W-1:0]          sqc_reg, sqv_reg, sqh_reg;
    logic                     cold_reg, vcold_reg, hot_reg;
    // stage 2
    logic [SQ_W+2:0]          sq7;
    logic [SQ_W+1:0]          off2;
    logic [SQ_W+1:0]          sens2;
    logic [SENS_F_W-1:0]      sens_hot;
    logic signed [TW_W-1:0]   tc_w;
    corr_t                    corr_next, corr_reg;

    assign en2      = !vld_reg[1] || out_ready;
    assign en1      = !vld_reg[0] || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en1) vld_reg[0] <= in_valid;
            if (en2) vld_reg[1] <= vld_reg[0];
        end
    end

    assign tw       = {in_data.temp[TEMP_W-1], in_data.temp};
    assign dc       = tw - TW_W'(T_REF);
    assign dv       = tw - TW_W'(T_VCOLD);
    assign dh       = tw - TW_W'(T_HOT);
    assign sqc_full = dc * dc;
    assign sqv_full = dv * dv;
    assign sqh_full = dh * dh;

    always_ff @(posedge aclk) begin
        if (en1) begin
            f_reg     <= in_data;
            sqc_reg   <= sqc_full[SQ_W-1:0];
            sqv_reg   <= sqv_full[SQ_W-1:0];
            sqh_reg   <= sqh_full[SQ_W-1:0];
            cold_reg  <= (tw < TW_W'(T_REF));
            vcold_reg <= (tw < TW_W'(T_VCOLD));
            hot_reg   <= (tw >= TW_W'(T_HOT));
        end
    end

    always_comb begin
        sq7      = {sqc_reg, 3'b000} - {3'b000, sqc_reg};
        off2     = cold_reg ? ({1'b0, sqc_reg, 1'b0} + {2'b00, sqc_reg}) : '0;
        sens2    = cold_reg ? {2'b00, sq7[SQ_W+2:3]} : '0;
        if (vcold_reg) begin
            sens2 = sens2 + {1'b0, sqv_reg, 1'b0};
        end
        sens_hot = hot_reg ? SENS_F_W'(sqh_reg[SQ_W-1:3]) : '0;
        tc_w     = {f_reg.temp[TEMP_W-1], f_reg.temp}
                 - (cold_reg ? TW_W'(f_reg.t2) : TW_W'(0));

        corr_next.d1   = f_reg.d1;
        corr_next.off  = $signed({{(OFF_F_W-OFF_W){f_reg.off[OFF_W-1]}}, f_reg.off})
                       - $signed(OFF_F_W'(off2));
        corr_next.sens = $signed({{(SENS_F_W-SENS_W){f_reg.sens[SENS_W-1]}}, f_reg.sens})
                       - $signed(SENS_F_W'(sens2)) + $signed(sens_hot);
        // saturate the temperature
        if (tc_w[TW_W-1] != tc_w[TW_W-2]) begin
            corr_next.tc = tc_w[TW_W-1] ? {1'b1, {(TEMP_W-1){1'b0}}}
                                        : {1'b0, {(TEMP_W-1){1'b1}}};
        end else begin
            corr_next.tc = tc_w[TEMP_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            corr_reg <= corr_next;
        end
    end

    assign out_valid = vld_reg[1];
    assign out_data  = corr_reg;

endmodule

// File: rtl/btc_press.sv
// Pressure stages: split product raw_pressure * SENS, recombine and shift,
// subtract OFF, shift and saturate into the output register. Depends on btc_pkg.
module btc_press
    import btc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  corr_t   in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic [2:0] vld_reg;
    logic       en1, en2, en3;

    // stage 1: partial products
    logic [PP_W-1:0]           pl_next, pl_reg;
    logic signed [PP_W-1:0]    ph_next, ph_reg;
    logic signed [OFF_F_W-1:0] off1_reg, off2_reg;
    logic signed [TEMP_W-1:0]  tc1_reg, tc2_reg;
    // stage 2: recombine
    logic signed [PROD_W-1:0]  prod;
    logic signed [Q_W-1:0]     q_next, q_reg;
    // stage 3: output
    logic signed [R_W-1:0]     r;
    logic signed [PF_W-1:0]    p_full;
    result_t                   res_next, res_reg;

    assign en3      = !vld_reg[2] || out_ready;
    assign en2      = !vld_reg[1] || en3;
    assign en1      = !vld_reg[0] || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en1) vld_reg[0] <= in_valid;
            if (en2) vld_reg[1] <= vld_reg[0];
            if (en3) vld_reg[2] <= vld_reg[1];
        end
    end

    assign pl_next = in_data.d1 * in_data.sens[SLO_W-1:0];
    assign ph_next = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[SENS_F_W-1:SLO_W]);

    assign prod   = ($signed(PROD_W'(ph_reg)) <<< SLO_W)
                  + $signed(PROD_W'(pl_reg));
    assign q_next = prod[PROD_W-1:SH_P1];

    assign r      = $signed({q_reg[Q_W-1], q_reg})
                  - $signed({{(R_W-OFF_F_W){off2_reg[OFF_F_W-1]}}, off2_reg});
    assign p_full = r[R_W-1:SH_P2];

    always_comb begin
        res_next.temperature_centi = tc2_reg;
        // saturate when the bits above the field disagree with its sign
        if (p_full[PF_W-1:PRES_W-1] != {(PF_W-PRES_W+1){p_full[PF_W-1]}}) begin
            res_next.pressure_pa = p_full[PF_W-1] ? {1'b1, {(PRES_W-1){1'b0}}}
                                                  : {1'b0, {(PRES_W-1){1'b1}}};
        end else begin
            res_next.pressure_pa = p_full[PRES_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            off1_reg <= in_data.off;
            tc1_reg  <= in_data.tc;
        end
        if (en2) begin
            q_reg    <= q_next;
            off2_reg <= off1_reg;
            tc2_reg  <= tc1_reg;
        end
        if (en3) begin
            res_reg  <= res_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_data  = res_reg;

endmodule

// File: test/barometer_temperature_compensation_test.sv
`timescale 1ns / 1ps
// Self-checking bench for barometer_temperature_compensation: readings in, checked results out.
// Depends on btc_pkg and the RTL of the block; it has its own compensation predictor.
module barometer_temperature_compensation_test;
    import btc_pkg::*;

    localparam int     RESET_CYCLES     = 11;
    localparam int     IDLE_PCT         = 18;       // chance of an idle cycle on either side
    localparam int     DRAIN_CYCLES     = 16;       // twice the eight register stages
    localparam int     CYCLE_LIMIT      = 200000;
    localparam int     PHASES           = 7;
    localparam int     RANDOM_PER_PHASE = 250;
    localparam int     DIRECTED_ROWS    = 16;
    localparam longint RAW_MAX          = (longint'(1) <<< RAW_W) - 1;
    localparam longint NEAR_SPREAD      = longint'(1) <<< 21;
    localparam longint PRES_MAX         = (longint'(1) <<< (PRES_W - 1)) - 1;
    localparam longint PRES_MIN         = -(longint'(1) <<< (PRES_W - 1));
    localparam longint TEMP_MAX         = (longint'(1) <<< (TEMP_W - 1)) - 1;
    localparam longint TEMP_MIN         = -(longint'(1) <<< (TEMP_W - 1));

    // Register indexes past the map; writes there must be dropped
    localparam logic [2:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [2:0] CFG_UNMAPPED_HI = 3'd7;

    // One row of the directed table; known rows carry a result read straight off the formulas
    typedef struct packed {
        logic [RAW_W-1:0]         raw_pressure;
        logic [RAW_W-1:0]         raw_temperature;
        logic                     known;
        logic signed [PRES_W-1:0] known_pressure;
        logic signed [TEMP_W-1:0] known_temperature;
    } reading_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // [23:0] raw_pressure, [47:24] raw_temperature
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [25:0] pressure_pa, [44:26] temperature_centi, pad
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Calibration words as the block should hold them
    cfg_t    calibration = '{RST_PSENS, RST_POFF, RST_STC, RST_OTC, RST_TREF, RST_SLOPE};
    result_t readings_due [$];
    int      failures    = 0;
    int      cycle_count = 0;
    logic    steady      = 1'b0;   // suppress idling on both sides

    // With the reset calibration the zero temperature difference sits at 33464 * 256 = 8566784.
    // Known rows: at dT = 0, OFF = 36924 * 2^16 and SENS = 40127 * 2^15, so with D1 = 0 the
    // pressure is -OFF / 2^15 = -73848, and with D1 = 2^21 it is (SENS - OFF) / 2^15 = -33721.
    reading_row_t directed_rows [DIRECTED_ROWS] = '{
        '{24'd0,        24'd8566784,  1'b1, -26'sd73848, 19'sd2000},
        '{24'd2097152,  24'd8566784,  1'b1, -26'sd33721, 19'sd2000},
        '{24'hFFFFFF,   24'd8566784,  1'b0, 26'sd0,      19'sd0},
        '{24'hFFFFFF,   24'd0,        1'b0, 26'sd0,      19'sd0},   // very cold, deepest
        '{24'd0,        24'd0,        1'b0, 26'sd0,      19'sd0},
        '{24'hFFFFFF,   24'hFFFFFF,   1'b0, 26'sd0,      19'sd0},   // hot, hottest
        '{24'd0,        24'hFFFFFF,   1'b0, 26'sd0,      19'sd0},
        '{24'd8000000,  24'd8566783,  1'b0, 26'sd0,      19'sd0},   // first cold step
        '{24'd8000000,  24'd8000000,  1'b0, 26'sd0,      19'sd0},   // cold
        '{24'd8000000,  24'd7529764,  1'b0, 26'sd0,      19'sd0},   // cold edge at -15.00 C
        '{24'd8000000,  24'd7529763,  1'b0, 26'sd0,      19'sd0},   // first very cold step
        '{24'd8000000,  24'd9307513,  1'b0, 26'sd0,      19'sd0},   // last normal step
        '{24'd8000000,  24'd9307514,  1'b0, 26'sd0,      19'sd0},   // hot edge at 45.00 C
        '{24'hAAAAAA,   24'h555555,   1'b0, 26'sd0,      19'sd0},
        '{24'h555555,   24'hAAAAAA,   1'b0, 26'sd0,      19'sd0},
        '{24'h800000,   24'h7FFFFF,   1'b0, 26'sd0,      19'sd0}
    };

    barometer_temperature_compensation DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Second-order compensation of one reading, worked in 64-bit signed arithmetic.
    // >>> on a signed operand is an arithmetic shift, i.e. floor division by a power of two.
    function automatic result_t compensate_reading(input cfg_t cal,
                                                   input logic [RAW_W-1:0] d1_raw,
                                                   input logic [RAW_W-1:0] d2_raw);
        longint  d1, d2, dt, temp, off, sens, t2, off2, sens2, dev, p, tc;
        result_t r;
        d1    = d1_raw;
        d2    = d2_raw;
        dt    = d2 - longint'(cal.reference_temperature) * 256;
        temp  = T_REF + ((dt * longint'(cal.temperature_slope)) >>> SH_T);
        off   = longint'(cal.pressure_offset) * 65536
              + ((longint'(cal.offset_temp_coeff) * dt) >>> SH_OFF);
        sens  = longint'(cal.pressure_sensitivity) * 32768
              + ((longint'(cal.sensitivity_temp_coeff) * dt) >>> SH_SENS);
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (temp < T_REF) begin
            dev   = temp - T_REF;
            t2    = (dt * dt) >>> SH_T2;
            off2  = 3 * dev * dev;
            sens2 = (7 * dev * dev) >>> 3;
            if (temp < T_VCOLD) begin
                dev   = temp - T_VCOLD;
                sens2 = sens2 + 2 * dev * dev;
            end
        end else if (temp >= T_HOT) begin
            dev   = temp - T_HOT;
            sens2 = -((dev * dev) >>> 3);
        end
        tc   = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
        p    = (((d1 * sens) >>> SH_P1) - off) >>> SH_P2;
        // Saturate both to their field ranges
        if (p > PRES_MAX) p = PRES_MAX;
        if (p < PRES_MIN) p = PRES_MIN;
        if (tc > TEMP_MAX) tc = TEMP_MAX;
        if (tc < TEMP_MIN) tc = TEMP_MIN;
        r.pressure_pa       = p[PRES_W-1:0];
        r.temperature_centi = tc[TEMP_W-1:0];
        return r;
    endfunction

    // Offer one reading, idling at random beforehand, and log its expectation on acceptance.
    // Keep s_tvalid high from one request to the next when there is no idle cycle between.
    task automatic send_reading(input logic [RAW_W-1:0] d1_raw, input logic [RAW_W-1:0] d2_raw,
                                input logic known, input result_t known_result);
        result_t want;
        want = known ? known_result : compensate_reading(calibration, d1_raw, d2_raw);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {d2_raw, d1_raw};
        do @(posedge aclk); while (!s_tready);
        readings_due.push_back(want);
    endtask

    // Drop valid, hold until every outstanding result is back, then let the pipe settle
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the word on the access edge.
    // The upper half of pwdata carries noise, since only sixteen bits are stored.
    task automatic write_register(input logic [2:0] idx, input logic [CAL_W-1:0] word);
        logic [15:0] noise;
        noise = 16'($urandom);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {noise, word};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_PSENS: calibration.pressure_sensitivity   = word;
            CFG_POFF:  calibration.pressure_offset        = word;
            CFG_STC:   calibration.sensitivity_temp_coeff = word;
            CFG_OTC:   calibration.offset_temp_coeff      = word;
            CFG_TREF:  calibration.reference_temperature  = word;
            CFG_SLOPE: calibration.temperature_slope      = word;
            default: ;
        endcase
    endtask

    // APB read; prdata is sampled on the access edge and compared with the stored word
    task automatic check_register(input cfg_idx_t idx);
        logic [CAL_W-1:0] stored;
        case (idx)
            CFG_PSENS: stored = calibration.pressure_sensitivity;
            CFG_POFF:  stored = calibration.pressure_offset;
            CFG_STC:   stored = calibration.sensitivity_temp_coeff;
            CFG_OTC:   stored = calibration.offset_temp_coeff;
            CFG_TREF:  stored = calibration.reference_temperature;
            default:   stored = calibration.temperature_slope;
        endcase
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata[CAL_W-1:0] !== stored) begin
            $display("%0t: register %0d read back expected %0d actual %0d",
                     $time, idx, stored, prdata[CAL_W-1:0]);
            failures++;
        end
    endtask

    // Write all six words, then read each one back
    task automatic program_calibration(input logic [CAL_W-1:0] words [6]);
        for (int i = 0; i < 6; i++) write_register(3'(i), words[i]);
        for (int i = 0; i < 6; i++) check_register(cfg_idx_t'(i));
    endtask

    // Random readings. Most raw temperatures land near the reference so that all four
    // temperature bands come up; the rest are extremes or anything at all.
    task automatic random_readings(input int count, input int steady_count, input int pause_at);
        longint      d2;
        logic [23:0] d1;
        int          pick;
        for (int i = 0; i < count; i++) begin
            steady <= (i < steady_count);
            if (i == pause_at) drain_pipeline();
            pick = $urandom_range(99);
            if (pick < 5)       d1 = '0;
            else if (pick < 10) d1 = '1;
            else                d1 = 24'($urandom);
            pick = $urandom_range(99);
            if (pick < 55) begin
                d2 = longint'(calibration.reference_temperature) * 256
                   + longint'($urandom_range(2 * NEAR_SPREAD)) - NEAR_SPREAD;
                if (d2 < 0) d2 = 0;
                if (d2 > RAW_MAX) d2 = RAW_MAX;
            end else if (pick < 62) begin
                d2 = 0;
            end else if (pick < 69) begin
                d2 = RAW_MAX;
            end else begin
                d2 = longint'($urandom_range(RAW_MAX));
            end
            send_reading(d1, d2[RAW_W-1:0], 1'b0, '0);
        end
        steady <= 1'b0;
    endtask

    // Result side: stall at random, compare each accepted result with the oldest expectation
    always @(posedge aclk) begin : result_check
        logic signed [PRES_W-1:0] got_pressure;
        logic signed [TEMP_W-1:0] got_temperature;
        result_t                  want;
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        if (aresetn && m_tvalid && m_tready) begin
            got_pressure    = m_tdata[PRES_W-1:0];
            got_temperature = m_tdata[PRES_W +: TEMP_W];
            if (readings_due.size() == 0) begin
                $display("%0t: unexpected result pressure %0d temperature %0d",
                         $time, got_pressure, got_temperature);
                failures++;
            end else begin
                want = readings_due.pop_front();
                if (got_pressure !== want.pressure_pa) begin
                    $display("%0t: pressure_pa expected %0d actual %0d",
                             $time, want.pressure_pa, got_pressure);
                    failures++;
                end
                if (got_temperature !== want.temperature_centi) begin
                    $display("%0t: temperature_centi expected %0d actual %0d",
                             $time, want.temperature_centi, got_temperature);
                    failures++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CAL_W-1:0] words [6];
        result_t          known_result;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset calibration: confirm the defaults, then walk the directed table
        for (int i = 0; i < 6; i++) check_register(cfg_idx_t'(i));
        foreach (directed_rows[i]) begin
            known_result.pressure_pa       = directed_rows[i].known_pressure;
            known_result.temperature_centi = directed_rows[i].known_temperature;
            send_reading(directed_rows[i].raw_pressure, directed_rows[i].raw_temperature,
                         directed_rows[i].known, known_result);
        end
        random_readings(RANDOM_PER_PHASE, 0, -1);

        for (int phase = 1; phase < PHASES; phase++) begin
            // Registers change only with the pipe empty
            drain_pipeline();
            for (int i = 0; i < 6; i++) begin
                case (phase)
                    1:       words[i] = '0;
                    2:       words[i] = '1;
                    6:       words[i] = '0;
                    default: words[i] = 16'($urandom);
                endcase
            end
            if (phase == 6) begin
                words[CFG_PSENS] = RST_PSENS;
                words[CFG_POFF]  = RST_POFF;
                words[CFG_STC]   = RST_STC;
                words[CFG_OTC]   = RST_OTC;
                words[CFG_TREF]  = RST_TREF;
                words[CFG_SLOPE] = RST_SLOPE;
            end
            program_calibration(words);
            // Writes past the map must leave every word alone; the results will show it
            if (phase == 1 || phase == 4) begin
                write_register(CFG_UNMAPPED_LO, 16'($urandom));
                write_register(CFG_UNMAPPED_HI, 16'hFFFF);
            end
            case (phase)
                3:       random_readings(RANDOM_PER_PHASE, 200, -1);   // no idling for a stretch
                4:       random_readings(RANDOM_PER_PHASE, 0, 125);    // stop and empty midway
                default: random_readings(RANDOM_PER_PHASE, 0, -1);
            endcase
        end

        drain_pipeline();
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
